>>> hw/rtl/array_table_search_delete_sort_defines.svh
// Assertion macros for the table search, delete and sort RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ARRAY_TABLE_SEARCH_DELETE_SORT_DEFINES_SVH
`define ARRAY_TABLE_SEARCH_DELETE_SORT_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define ATSDS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the same cycle as its antecedent
`define ATSDS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/atsds_pkg.sv
// Package for the table search, delete and sort block: opcodes, status codes,
// controller states and the command and status structs. Depends on nothing.
package atsds_pkg;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_APPEND  = 3'd1;
    localparam logic [2:0] OP_SEARCH  = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_SORT    = 3'd4;
    localparam logic [2:0] OP_READOUT = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH,
        S_PASS_START,
        S_PASS_LOAD,
        S_PASS_RD,
        S_PASS_CMP,
        S_PASS_END,
        S_READ_RD,
        S_READ_EMIT,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {CNT_HOLD, CNT_CLEAR, CNT_INC, CNT_DEC} count_op_t;
    typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_INC} idx_op_t;
    typedef enum logic [1:0] {HIT_HOLD, HIT_ZERO, HIT_SET} hit_op_t;
    typedef enum logic [1:0] {LIM_HOLD, LIM_INIT, LIM_DEC} limit_op_t;
    typedef enum logic [1:0] {RD_NONE, RD_IDX, RD_NEXT} rd_sel_t;
    typedef enum logic [2:0] {WR_NONE, WR_APPEND, WR_SHIFT, WR_SWAP, WR_CARRY} wr_sel_t;
    typedef enum logic [1:0] {CARRY_HOLD, CARRY_LOAD, CARRY_SWAP} carry_op_t;
    typedef enum logic [2:0] {
        PEND_HOLD, PEND_OK, PEND_FULL, PEND_APPEND, PEND_HIT, PEND_MISS, PEND_EMPTY
    } pend_op_t;
    typedef enum logic [1:0] {OUT_NONE, OUT_PEND, OUT_ENTRY} out_op_t;

    typedef struct packed {
        logic      capture;
        count_op_t count_op;
        idx_op_t   idx_op;
        hit_op_t   hit_op;
        limit_op_t limit_op;
        rd_sel_t   rd_sel;
        wr_sel_t   wr_sel;
        carry_op_t carry_op;
        pend_op_t  pend_op;
        out_op_t   out_op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       count_zero;
        logic       count_full;
        logic       count_small;
        logic       match;
        logic       scan_last;
        logic       shift_more;
        logic       pass_last;
        logic       sort_final;
        logic       slot_free;
    } dp_sts_t;

endpackage

>>> hw/rtl/atsds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module atsds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/atsds_dp.sv
// Datapath: entry RAM, fill count, scan index, bubble carry and result register.
// Depends on atsds_pkg, atsds_ram and the assertion macro header.
`include "array_table_search_delete_sort_defines.svh"

module atsds_dp #(
    parameter int TABLE_DEPTH = 16,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          opcode,
    input  atsds_pkg::word_t    operand_value,
    input  atsds_pkg::dp_cmd_t  cmd,
    output atsds_pkg::dp_sts_t  sts,
    output atsds_pkg::word_t    result_value,
    output logic [CW-1:0]       position,
    output logic [CW-1:0]       entry_count,
    output logic [1:0]          status,
    output logic                last_result,
    output logic                res_valid,
    input  logic                res_ready
);

    import atsds_pkg::*;

    logic [2:0]    opcode_reg;
    word_t         operand_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hit_reg, hit_next;
    logic [CW-1:0] limit_reg, limit_next;
    word_t         carry_reg, carry_next;
    logic [CW-1:0] pend_pos_reg, pend_pos_next;
    logic [1:0]    pend_status_reg, pend_status_next;

    word_t         result_value_reg, result_value_next;
    logic [CW-1:0] position_reg, position_next;
    logic [CW-1:0] entry_count_reg, entry_count_next;
    logic [1:0]    status_reg, status_next;
    logic          last_reg, last_next;
    logic          res_valid_reg, res_valid_next;

    logic [CW-1:0] idx_plus1;
    logic [CW-1:0] count_plus1;
    word_t         rd_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;
    logic          greater;

    assign idx_plus1   = idx_reg + CW'(1);
    assign count_plus1 = count_reg + CW'(1);
    assign greater     = carry_reg > rd_data;

    atsds_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_en   = (cmd.rd_sel != RD_NONE);
    assign rd_addr = (cmd.rd_sel == RD_NEXT) ? idx_plus1[AW-1:0] : idx_reg[AW-1:0];

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg[AW-1:0];
        wr_data = carry_reg;
        unique case (cmd.wr_sel)
            WR_NONE:   wr_en = 1'b0;
            WR_APPEND:
            begin
                wr_addr = count_reg[AW-1:0];
                wr_data = operand_reg;
            end
            WR_SHIFT:  wr_data = rd_data;
            WR_SWAP:   wr_data = greater ? rd_data : carry_reg;
            WR_CARRY:  wr_data = carry_reg;
            default:   wr_en = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        idx_next         = idx_reg;
        hit_next         = hit_reg;
        limit_next       = limit_reg;
        carry_next       = carry_reg;
        pend_pos_next    = pend_pos_reg;
        pend_status_next = pend_status_reg;

        unique case (cmd.count_op)
            CNT_CLEAR: count_next = '0;
            CNT_INC:   count_next = count_plus1;
            CNT_DEC:   count_next = count_reg - CW'(1);
            default:   count_next = count_reg;
        endcase

        unique case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_plus1;
            default:  idx_next = idx_reg;
        endcase

        unique case (cmd.hit_op)
            HIT_ZERO: hit_next = '0;
            HIT_SET:  hit_next = idx_plus1;
            default:  hit_next = hit_reg;
        endcase

        unique case (cmd.limit_op)
            LIM_INIT: limit_next = count_reg - CW'(1);
            LIM_DEC:  limit_next = limit_reg - CW'(1);
            default:  limit_next = limit_reg;
        endcase

        unique case (cmd.carry_op)
            CARRY_LOAD: carry_next = rd_data;
            CARRY_SWAP: carry_next = greater ? carry_reg : rd_data;
            default:    carry_next = carry_reg;
        endcase

        unique case (cmd.pend_op)
            PEND_OK:
            begin
                pend_pos_next    = '0;
                pend_status_next = ST_OK;
            end
            PEND_FULL:
            begin
                pend_pos_next    = '0;
                pend_status_next = ST_FULL;
            end
            PEND_APPEND:
            begin
                pend_pos_next    = count_plus1;
                pend_status_next = ST_OK;
            end
            PEND_HIT:
            begin
                pend_pos_next    = hit_reg;
                pend_status_next = (hit_reg == '0) ? ST_NOTFOUND : ST_OK;
            end
            PEND_MISS:
            begin
                pend_pos_next    = '0;
                pend_status_next = ST_NOTFOUND;
            end
            PEND_EMPTY:
            begin
                pend_pos_next    = '0;
                pend_status_next = ST_EMPTY;
            end
            default:
            begin
                pend_pos_next    = pend_pos_reg;
                pend_status_next = pend_status_reg;
            end
        endcase
    end

    always_comb
    begin
        result_value_next = result_value_reg;
        position_next     = position_reg;
        entry_count_next  = entry_count_reg;
        status_next       = status_reg;
        last_next         = last_reg;
        res_valid_next    = res_valid_reg && !res_ready;
        unique case (cmd.out_op)
            OUT_PEND:
            begin
                result_value_next = (pend_status_reg == ST_EMPTY) ? '0 : operand_reg;
                position_next     = pend_pos_reg;
                entry_count_next  = count_reg;
                status_next       = pend_status_reg;
                last_next         = 1'b1;
                res_valid_next    = 1'b1;
            end
            OUT_ENTRY:
            begin
                result_value_next = rd_data;
                position_next     = idx_plus1;
                entry_count_next  = count_reg;
                status_next       = ST_OK;
                last_next         = (idx_plus1 == count_reg);
                res_valid_next    = 1'b1;
            end
            default:
            begin
                result_value_next = result_value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            idx_reg         <= '0;
            hit_reg         <= '0;
            limit_reg       <= '0;
            pend_status_reg <= ST_OK;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            hit_reg         <= hit_next;
            limit_reg       <= limit_next;
            pend_status_reg <= pend_status_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opcode_reg  <= opcode;
            operand_reg <= operand_value;
        end
        carry_reg        <= carry_next;
        pend_pos_reg     <= pend_pos_next;
        result_value_reg <= result_value_next;
        position_reg     <= position_next;
        entry_count_reg  <= entry_count_next;
        status_reg       <= status_next;
        last_reg         <= last_next;
    end

    assign sts.opcode      = opcode_reg;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.count_full  = (count_reg == CW'(TABLE_DEPTH));
    assign sts.count_small = (count_reg < CW'(2));
    assign sts.match       = (rd_data == operand_reg);
    assign sts.scan_last   = (idx_plus1 == count_reg);
    assign sts.shift_more  = (idx_plus1 < count_reg);
    assign sts.pass_last   = (idx_plus1 == limit_reg);
    assign sts.sort_final  = (limit_reg == CW'(1));
    assign sts.slot_free   = !res_valid_reg || res_ready;

    assign result_value = result_value_reg;
    assign position     = position_reg;
    assign entry_count  = entry_count_reg;
    assign status       = status_reg;
    assign last_result  = last_reg;
    assign res_valid    = res_valid_reg;

    `ATSDS_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(TABLE_DEPTH), "fill count beyond depth")
    `ATSDS_ASSERT_IMPLIES(a_append_room, clk, rst_n, cmd.count_op == CNT_INC, count_reg < CW'(TABLE_DEPTH), "append into a full table")
    `ATSDS_ASSERT_IMPLIES(a_write_inside, clk, rst_n, cmd.wr_sel == WR_SHIFT || cmd.wr_sel == WR_SWAP || cmd.wr_sel == WR_CARRY, idx_reg < count_reg, "entry write beyond fill count")
    `ATSDS_ASSERT_IMPLIES(a_slot_free, clk, rst_n, cmd.out_op != OUT_NONE, !res_valid_reg || res_ready, "result overwritten before it was taken")

endmodule

>>> hw/rtl/atsds_ctrl.sv
// Controller state machine: sequences clear, append, scan, shift, bubble passes
// and readout over the datapath. Depends on atsds_pkg.
module atsds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_ready,
    input  atsds_pkg::dp_sts_t sts,
    output atsds_pkg::dp_cmd_t cmd
);

    import atsds_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.opcode)
                    OP_CLEAR:   state_next = S_EMIT;
                    OP_APPEND:  state_next = S_EMIT;
                    OP_SEARCH:  state_next = sts.count_zero ? S_EMIT : S_SCAN_RD;
                    OP_DELETE:  state_next = sts.count_zero ? S_EMIT : S_SCAN_RD;
                    OP_SORT:    state_next = sts.count_small ? S_EMIT : S_PASS_START;
                    OP_READOUT: state_next = sts.count_zero ? S_EMIT : S_READ_RD;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_SCAN_RD:    state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                priority if (sts.opcode == OP_DELETE && sts.match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:   state_next = sts.shift_more ? S_SHIFT_WR : S_FINISH;
            S_SHIFT_WR:   state_next = S_SHIFT_RD;
            S_FINISH:     state_next = S_EMIT;
            S_PASS_START: state_next = S_PASS_LOAD;
            S_PASS_LOAD:  state_next = S_PASS_RD;
            S_PASS_RD:    state_next = S_PASS_CMP;
            S_PASS_CMP:   state_next = sts.pass_last ? S_PASS_END : S_PASS_RD;
            S_PASS_END:   state_next = sts.sort_final ? S_EMIT : S_PASS_START;
            S_READ_RD:    state_next = S_READ_EMIT;
            S_READ_EMIT:
            begin
                if (sts.slot_free)
                begin
                    state_next = sts.scan_last ? S_IDLE : S_READ_RD;
                end
            end
            S_EMIT:
            begin
                if (sts.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_ready     = (state_reg == S_IDLE);
        cmd.capture  = 1'b0;
        cmd.count_op = CNT_HOLD;
        cmd.idx_op   = IDX_HOLD;
        cmd.hit_op   = HIT_HOLD;
        cmd.limit_op = LIM_HOLD;
        cmd.rd_sel   = RD_NONE;
        cmd.wr_sel   = WR_NONE;
        cmd.carry_op = CARRY_HOLD;
        cmd.pend_op  = PEND_HOLD;
        cmd.out_op   = OUT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = op_valid;
            end
            S_DECODE:
            begin
                unique case (sts.opcode)
                    OP_CLEAR:
                    begin
                        cmd.count_op = CNT_CLEAR;
                        cmd.pend_op  = PEND_OK;
                    end
                    OP_APPEND:
                    begin
                        if (sts.count_full)
                        begin
                            cmd.pend_op = PEND_FULL;
                        end
                        else
                        begin
                            cmd.wr_sel   = WR_APPEND;
                            cmd.count_op = CNT_INC;
                            cmd.pend_op  = PEND_APPEND;
                        end
                    end
                    OP_SEARCH, OP_DELETE:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        cmd.hit_op = HIT_ZERO;
                        if (sts.count_zero)
                        begin
                            cmd.pend_op = PEND_MISS;
                        end
                    end
                    OP_SORT:
                    begin
                        cmd.idx_op   = IDX_ZERO;
                        cmd.limit_op = LIM_INIT;
                        if (sts.count_small)
                        begin
                            cmd.pend_op = PEND_OK;
                        end
                    end
                    OP_READOUT:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        if (sts.count_zero)
                        begin
                            cmd.pend_op = PEND_EMPTY;
                        end
                    end
                    default:
                    begin
                        cmd.pend_op = PEND_HOLD;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd_sel = RD_IDX;
            end
            S_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    cmd.hit_op = HIT_SET;
                end
                if (!(sts.opcode == OP_DELETE && sts.match) && !sts.scan_last)
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.shift_more)
                begin
                    cmd.rd_sel = RD_NEXT;
                end
                else
                begin
                    cmd.count_op = CNT_DEC;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_INC;
            end
            S_FINISH:
            begin
                cmd.pend_op = PEND_HIT;
            end
            S_PASS_START:
            begin
                cmd.rd_sel = RD_IDX;
            end
            S_PASS_LOAD:
            begin
                cmd.carry_op = CARRY_LOAD;
            end
            S_PASS_RD:
            begin
                cmd.rd_sel = RD_NEXT;
            end
            S_PASS_CMP:
            begin
                cmd.wr_sel   = WR_SWAP;
                cmd.carry_op = CARRY_SWAP;
                cmd.idx_op   = IDX_INC;
            end
            S_PASS_END:
            begin
                cmd.wr_sel   = WR_CARRY;
                cmd.limit_op = LIM_DEC;
                cmd.idx_op   = IDX_ZERO;
                if (sts.sort_final)
                begin
                    cmd.pend_op = PEND_OK;
                end
            end
            S_READ_RD:
            begin
                cmd.rd_sel = RD_IDX;
            end
            S_READ_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_op = OUT_ENTRY;
                    if (!sts.scan_last)
                    begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_op = OUT_PEND;
                end
            end
            default:
            begin
                cmd.out_op = OUT_NONE;
            end
        endcase
    end

endmodule

>>> hw/rtl/array_table_search_delete_sort.sv
// Table of signed 32-bit words with a fill count: clear, append, search for the
// last match, delete the first match with shift-down, bubble sort and readout.
// Depends on atsds_pkg, atsds_ctrl and atsds_dp.
//
// One operation is taken at a time; the next is accepted once the controller
// is back in idle, even while the final result still waits in the output
// register. All entry traffic goes through one RAM with one read and one write
// port and a registered read, so each entry visited takes a read state followed
// by a compare, shift-write or emit state. With n entries stored, delete of the
// entry at position k scans to k, then shifts the rest down; sort runs n - 1
// bubble passes; readout gives one result per entry while the consumer keeps
// taking them and waits while it stalls. Undefined opcodes are dropped without
// a result. The entry RAM needs no initialisation: only entries below the fill
// count are ever read.
module array_table_search_delete_sort #(
    parameter int TABLE_DEPTH = 16,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_ready,
    input  logic [2:0]       opcode,
    input  atsds_pkg::word_t operand_value,
    output logic             res_valid,
    input  logic             res_ready,
    output atsds_pkg::word_t result_value,
    output logic [CW-1:0]    position,
    output logic [CW-1:0]    entry_count,
    output logic [1:0]       status,
    output logic             last_result
);

    import atsds_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    atsds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atsds_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .operand_value (operand_value),
        .cmd           (cmd),
        .sts           (sts),
        .result_value  (result_value),
        .position      (position),
        .entry_count   (entry_count),
        .status        (status),
        .last_result   (last_result),
        .res_valid     (res_valid),
        .res_ready     (res_ready)
    );

endmodule

>>> dv/tb_top.sv
// Self-checking bench for the table search, delete and sort block: a queued
// driver, a result monitor and a table predictor that runs on accepted beats.
// Depends on atsds_pkg and array_table_search_delete_sort.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import atsds_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int RANDOM_OPS = 240;

    localparam word_t W_MIN = 32'h8000_0000;
    localparam word_t W_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [2:0] code;
        word_t      operand;
    } table_op_t;

    typedef struct {
        word_t          value;
        logic [CW-1:0]  pos;
        logic [CW-1:0]  count;
        logic [1:0]     stat;
        logic           last;
    } table_result_t;

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          op_valid      = 1'b0;
    logic          op_ready;
    logic [2:0]    opcode        = OP_CLEAR;
    word_t         operand_value = '0;
    logic          res_valid;
    logic          res_ready     = 1'b0;
    word_t         result_value;
    logic [CW-1:0] position;
    logic [CW-1:0] entry_count;
    logic [1:0]    status;
    logic          last_result;

    table_op_t     op_backlog[$];
    table_result_t awaited_results[$];

    word_t         shadow_table[DEPTH];
    int            shadow_fill;
    word_t         operand_pool[8];

    table_op_t     next_op;
    table_result_t seen;
    int            burst_left = 1;
    int            gap_left   = 0;
    logic [7:0]    stall_pat  = 8'hFF;
    logic [5:0]    stall_phase = '0;

    int            ops_accepted   = 0;
    int            results_checked = 0;
    int            full_refusals  = 0;
    int            deep_sorts     = 0;
    int            fault_count    = 0;

    array_table_search_delete_sort #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .opcode       (opcode),
        .operand_value(operand_value),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .result_value (result_value),
        .position     (position),
        .entry_count  (entry_count),
        .status       (status),
        .last_result  (last_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void push_result(word_t v, int p, logic [1:0] s, logic l);
        table_result_t r;
        r.value = v;
        r.pos   = p[CW-1:0];
        r.count = shadow_fill[CW-1:0];
        r.stat  = s;
        r.last  = l;
        awaited_results.push_back(r);
    endfunction

    function automatic void apply_table_op(logic [2:0] code, word_t val);
        int    hit;
        word_t tmp;
        hit = 0;
        case (code)
            OP_CLEAR:
            begin
                shadow_fill = 0;
                push_result(val, 0, ST_OK, 1'b1);
            end
            OP_APPEND:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    full_refusals++;
                    push_result(val, 0, ST_FULL, 1'b1);
                end
                else
                begin
                    shadow_table[shadow_fill] = val;
                    shadow_fill++;
                    push_result(val, shadow_fill, ST_OK, 1'b1);
                end
            end
            OP_SEARCH:
            begin
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_table[i] == val)
                        hit = i + 1;
                push_result(val, hit, (hit != 0) ? ST_OK : ST_NOTFOUND, 1'b1);
            end
            OP_DELETE:
            begin
                for (int i = 0; i < shadow_fill; i++)
                    if (hit == 0 && shadow_table[i] == val)
                        hit = i + 1;
                if (hit != 0)
                begin
                    for (int j = hit - 1; j + 1 < shadow_fill; j++)
                        shadow_table[j] = shadow_table[j + 1];
                    shadow_fill--;
                end
                push_result(val, hit, (hit != 0) ? ST_OK : ST_NOTFOUND, 1'b1);
            end
            OP_SORT:
            begin
                if (shadow_fill > 1)
                    deep_sorts++;
                for (int i = 0; i + 1 < shadow_fill; i++)
                    for (int j = 0; j + 1 < shadow_fill - i; j++)
                        if (shadow_table[j] > shadow_table[j + 1])
                        begin
                            tmp                 = shadow_table[j];
                            shadow_table[j]     = shadow_table[j + 1];
                            shadow_table[j + 1] = tmp;
                        end
                push_result(val, 0, ST_OK, 1'b1);
            end
            OP_READOUT:
            begin
                if (shadow_fill == 0)
                    push_result('0, 0, ST_EMPTY, 1'b1);
                else
                    for (int i = 0; i < shadow_fill; i++)
                        push_result(shadow_table[i], i + 1, ST_OK, i + 1 == shadow_fill);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void report_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void queue_op(logic [2:0] code, word_t val);
        table_op_t t;
        t.code    = code;
        t.operand = val;
        op_backlog.push_back(t);
    endfunction

    function automatic word_t pick_operand();
        if ($urandom_range(0, 9) < 7)
            return operand_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return OP_CLEAR;
        if (r < 44) return OP_APPEND;
        if (r < 59) return OP_SEARCH;
        if (r < 74) return OP_DELETE;
        if (r < 82) return OP_SORT;
        if (r < 97) return OP_READOUT;
        return 3'($urandom_range(6, 7));
    endfunction

    // driver: hold the beat until accepted, then advance through the backlog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid      <= 1'b0;
            opcode        <= OP_CLEAR;
            operand_value <= '0;
        end
        else
        begin
            if (op_valid && op_ready)
            begin
                apply_table_op(opcode, operand_value);
                ops_accepted++;
            end
            if (!op_valid || op_ready)
            begin
                if (gap_left != 0 || op_backlog.size() == 0)
                begin
                    op_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    next_op        = op_backlog.pop_front();
                    op_valid      <= 1'b1;
                    opcode        <= next_op.code;
                    operand_value <= next_op.operand;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern, reloaded when the phase counter reaches its last value
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready   <= 1'b0;
            stall_phase <= '0;
        end
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            res_ready   <= stall_pat[stall_phase[2:0]];
            if (stall_phase == 6'd63)
            begin
                case ($urandom_range(0, 4))
                    0: stall_pat <= 8'hFF;
                    1: stall_pat <= 8'($urandom) | 8'h01;
                    2: stall_pat <= 8'h55;
                    3: stall_pat <= 8'h01;
                    default: stall_pat <= 8'hF0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (awaited_results.size() == 0)
                report_fault($sformatf("unexpected result: value %0d pos %0d count %0d st %0d last %0b",
                    result_value, position, entry_count, status, last_result));
            else
            begin
                seen = awaited_results.pop_front();
                results_checked++;
                if (result_value !== seen.value || position !== seen.pos ||
                    entry_count !== seen.count || status !== seen.stat ||
                    last_result !== seen.last)
                    report_fault($sformatf(
                        "mismatch: exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                        seen.value, seen.pos, seen.count, seen.stat, seen.last,
                        result_value, position, entry_count, status, last_result));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        int         counted;
        int         n;
        logic [2:0] code;
        shadow_fill     = 0;
        operand_pool[0] = W_MIN;
        operand_pool[1] = W_MAX;
        operand_pool[2] = '0;
        operand_pool[3] = -1;
        operand_pool[4] = 1;
        for (int i = 5; i < 8; i++)
            operand_pool[i] = $urandom;

        queue_op(OP_READOUT, 32'sd9);
        queue_op(OP_SEARCH, 32'sd7);
        queue_op(OP_DELETE, 32'sd7);
        queue_op(OP_SORT, W_MIN);
        queue_op(OP_CLEAR, W_MAX);
        queue_op(OP_APPEND, W_MIN);
        queue_op(OP_APPEND, W_MAX);
        queue_op(OP_APPEND, '0);
        queue_op(OP_APPEND, -1);
        queue_op(OP_APPEND, W_MAX);
        queue_op(OP_APPEND, 32'sd1);
        queue_op(OP_SEARCH, W_MAX);
        queue_op(OP_SEARCH, 32'sd2);
        queue_op(OP_DELETE, W_MAX);
        queue_op(OP_DELETE, W_MIN);
        queue_op(OP_READOUT, '0);
        queue_op(OP_SORT, -1);
        queue_op(OP_READOUT, W_MAX);
        queue_op(3'd6, W_MAX);
        queue_op(3'd7, W_MIN);
        queue_op(OP_DELETE, W_MAX);
        queue_op(OP_SEARCH, -1);
        queue_op(OP_CLEAR, '0);
        queue_op(OP_READOUT, -1);

        counted = 0;
        while (counted < RANDOM_OPS)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                // fill to the brim and at times past it, then read, sort and read again
                n = $urandom_range(DEPTH, DEPTH + 2);
                queue_op(OP_CLEAR, pick_operand());
                for (int k = 0; k < n; k++)
                    queue_op(OP_APPEND, pick_operand());
                queue_op(OP_READOUT, pick_operand());
                queue_op(OP_SORT, pick_operand());
                queue_op(OP_READOUT, pick_operand());
                counted += n + 4;
            end
            else
            begin
                code = pick_opcode();
                queue_op(code, pick_operand());
                if (code <= OP_READOUT)
                    counted++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || op_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("tb_top: %0d operations accepted, %0d results checked", ops_accepted,
            results_checked);
        $display("tb_top: %0d appends refused on a full table, %0d sorts of two or more entries",
            full_refusals, deep_sorts);
        if (fault_count == 0 && awaited_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
